// File: rtl/core/rsie_pkg.sv
// shared constants, command codes and pipeline types for the instruction executor
`default_nettype none

package rsie_pkg;

  // data store size in bytes, a power of two
  localparam int MEM_BYTES = 1024;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int DS_ROWS   = MEM_BYTES / 4;
  localparam int ROW_AW    = $clog2(DS_ROWS);

  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = $clog2(RF_DEPTH);

  // config port: one 32-bit register at byte address 0
  localparam int CFG_AW    = 3;
  localparam logic [CFG_AW-3:0] REG_PC_BASE = '0;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_XOR  = 4'd2,
    CMD_ADDI = 4'd3,
    CMD_SUBI = 4'd4,
    CMD_LW   = 4'd5,
    CMD_SW   = 4'd6,
    CMD_BLTZ = 4'd7,
    CMD_BNEZ = 4'd8,
    CMD_EOP  = 4'd9
  } cmd_t;

  // execute-to-writeback stage contents
  typedef struct packed {
    logic [31:0]      npc;
    logic             taken;
    logic             wv;
    logic [RF_AW-1:0] wi;
    logic [31:0]      wval;
    logic             is_lw;
    logic [1:0]       a0;
    logic             halted;
  } s2_t;

endpackage

`default_nettype wire

// File: rtl/core/rsie_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module rsie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/risc_subset_instruction_executor.sv
// instruction executor: register file, byte data store, pc and halt flag
// pipeline: read into stage 1, execute into stage 2, then writeback
//   into the result register; a stalled result holds the whole pipeline
// throughput: one instruction per cycle unless stalled; the register file ram read
//   latency is covered by forwarding from the writeback stage and the last write-back
// reset: control state cleared, pc and start address to 0, halt flag low; register file
//   entries read as all ones until written; the data store is swept to 0xFF after reset,
//   one row of four bytes per cycle (MEM_BYTES/4 = 256 rows), with in_stall held high
`default_nettype none

module risc_subset_instruction_executor
  import rsie_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        in_cmd,
  input  wire logic [4:0]        in_dest_reg,
  input  wire logic [4:0]        in_src_a_reg,
  input  wire logic [4:0]        in_src_b_reg,
  input  wire logic signed [15:0] in_immediate,
  input  wire logic [31:0]       in_branch_target,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_next_pc,
  output logic                   out_branch_taken,
  output logic                   out_write_valid,
  output logic [4:0]             out_write_index,
  output logic [31:0]            out_write_value,
  output logic                   out_halted,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // ---------------------------------------------------------------- control
  logic              adv;
  logic              acc;
  logic              cfg_wr;
  logic              clr_busy_r;
  logic [ROW_AW-1:0] clr_row_r;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = clr_busy_r || !adv;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      clr_row_r <= clr_row_r + 1'b1;
      if (clr_row_r == ROW_AW'(DS_ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- config
  logic [31:0] start_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[CFG_AW-1:2] == REG_PC_BASE);
  assign prdata = (paddr[CFG_AW-1:2] == REG_PC_BASE) ? start_r : 32'd0;

  // ---------------------------------------------------------------- stage 1 regs
  logic              s1_valid_r;
  logic [3:0]        s1_cmd_r;
  logic [RF_AW-1:0]  s1_rd_r;
  logic [RF_AW-1:0]  s1_ra_r;
  logic [RF_AW-1:0]  s1_rb_r;
  logic [15:0]       s1_imm_r;
  logic [31:0]       s1_tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r <= in_cmd;
      s1_rd_r  <= in_dest_reg;
      s1_ra_r  <= in_src_a_reg;
      s1_rb_r  <= in_src_b_reg;
      s1_imm_r <= in_immediate;
      s1_tgt_r <= in_branch_target;
    end
  end

  // ---------------------------------------------------------------- register file
  logic [31:0]         rf_a_rdata;
  logic [31:0]         rf_b_rdata;
  logic                rf_we;
  logic [RF_DEPTH-1:0] rf_vld_r;
  logic                s2_valid_r;
  s2_t                 s2_r;
  logic [31:0]         s2_wval;

  assign rf_we = adv && s2_valid_r && s2_r.wv;

  // two copies, written together, one per read port
  rsie_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_r.wi),
    .wdata (s2_wval),
    .re    (acc),
    .raddr (in_src_a_reg),
    .rdata (rf_a_rdata)
  );

  rsie_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (s2_r.wi),
    .wdata (s2_wval),
    .re    (acc),
    .raddr (in_src_b_reg),
    .rdata (rf_b_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[s2_r.wi] <= 1'b1;
    end
  end

  // last write-back, done at the same edge the stage 1 operands were read
  logic             lw_valid_r;
  logic [RF_AW-1:0] lw_idx_r;
  logic [31:0]      lw_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (adv) begin
      lw_valid_r <= rf_we;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      lw_idx_r <= s2_r.wi;
      lw_val_r <= s2_wval;
    end
  end

  // operand forwarding: writeback stage first, then last write, then ram
  logic [31:0] a_val;
  logic [31:0] b_val;

  always_comb begin
    if (s2_valid_r && s2_r.wv && (s2_r.wi == s1_ra_r)) begin
      a_val = s2_wval;
    end else if (lw_valid_r && (lw_idx_r == s1_ra_r)) begin
      a_val = lw_val_r;
    end else if (rf_vld_r[s1_ra_r]) begin
      a_val = rf_a_rdata;
    end else begin
      a_val = '1;
    end
  end

  always_comb begin
    if (s2_valid_r && s2_r.wv && (s2_r.wi == s1_rb_r)) begin
      b_val = s2_wval;
    end else if (lw_valid_r && (lw_idx_r == s1_rb_r)) begin
      b_val = lw_val_r;
    end else if (rf_vld_r[s1_rb_r]) begin
      b_val = rf_b_rdata;
    end else begin
      b_val = '1;
    end
  end

  // ---------------------------------------------------------------- execute
  logic [31:0]       pc_r;
  logic              halt_r;
  logic [31:0]       imm32;
  logic [31:0]       mem_addr;
  logic [MEM_AW-1:0] addr_m;
  logic              do_sw;
  logic              do_lw;
  s2_t               s2_nxt;

  assign imm32    = {{16{s1_imm_r[15]}}, s1_imm_r};
  assign mem_addr = b_val + imm32;
  assign addr_m   = mem_addr[MEM_AW-1:0];

  always_comb begin
    s2_nxt        = '0;
    s2_nxt.npc    = pc_r + 32'd4;
    s2_nxt.a0     = addr_m[1:0];
    s2_nxt.halted = halt_r;
    do_sw         = 1'b0;
    do_lw         = 1'b0;
    if (halt_r) begin
      s2_nxt.npc = pc_r;
    end else begin
      case (s1_cmd_r)
        CMD_ADD: begin
          s2_nxt.wv   = 1'b1;
          s2_nxt.wval = a_val + b_val;
        end
        CMD_SUB: begin
          s2_nxt.wv   = 1'b1;
          s2_nxt.wval = a_val - b_val;
        end
        CMD_XOR: begin
          s2_nxt.wv   = 1'b1;
          s2_nxt.wval = a_val ^ b_val;
        end
        CMD_ADDI: begin
          s2_nxt.wv   = 1'b1;
          s2_nxt.wval = a_val + imm32;
        end
        CMD_SUBI: begin
          s2_nxt.wv   = 1'b1;
          s2_nxt.wval = a_val - imm32;
        end
        CMD_LW: begin
          s2_nxt.wv    = 1'b1;
          s2_nxt.is_lw = 1'b1;
          do_lw        = 1'b1;
        end
        CMD_SW: begin
          do_sw = 1'b1;
        end
        CMD_BLTZ: begin
          s2_nxt.taken = a_val[31];
        end
        CMD_BNEZ: begin
          s2_nxt.taken = (a_val != 32'd0);
        end
        CMD_EOP: begin
          s2_nxt.halted = 1'b1;
          s2_nxt.npc    = pc_r;
        end
        default: begin
        end
      endcase
      if (s2_nxt.taken) begin
        s2_nxt.npc = s1_tgt_r;
      end
      if (s2_nxt.wv) begin
        s2_nxt.wi = s1_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      start_r <= '0;
      halt_r  <= 1'b0;
    end else if (cfg_wr) begin
      start_r <= pwdata;
      pc_r    <= pwdata;
    end else if (adv && s1_valid_r) begin
      pc_r   <= s2_nxt.npc;
      halt_r <= s2_nxt.halted;
    end
  end

  // ---------------------------------------------------------------- data store
  // four byte lanes; lane l holds byte addresses with addr % 4 == l
  logic [7:0] ds_rdata [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [ROW_AW-1:0] row_base;
    logic [ROW_AW-1:0] row_l;
    logic [1:0]        byte_i;
    logic [7:0]        sw_byte;
    logic              we_l;
    logic [ROW_AW-1:0] waddr_l;
    logic [7:0]        wdata_l;

    assign row_base = addr_m[MEM_AW-1:2];
    // a word crosses into the next row for lanes below the start offset
    assign row_l    = (2'(l) < addr_m[1:0]) ? row_base + 1'b1 : row_base;
    assign byte_i   = 2'(l) - addr_m[1:0];
    assign sw_byte  = 8'(a_val >> {byte_i, 3'b000});
    assign we_l     = clr_busy_r || (adv && s1_valid_r && do_sw);
    assign waddr_l  = clr_busy_r ? clr_row_r : row_l;
    assign wdata_l  = clr_busy_r ? 8'hFF : sw_byte;

    rsie_ram #(.WIDTH(8), .DEPTH(DS_ROWS)) u_ds (
      .clk   (clk),
      .we    (we_l),
      .waddr (waddr_l),
      .wdata (wdata_l),
      .re    (adv && s1_valid_r && do_lw),
      .raddr (row_l),
      .rdata (ds_rdata[l])
    );
  end

  // ---------------------------------------------------------------- writeback
  logic [31:0] ld_word;

  always_comb begin
    ld_word = '0;
    for (int k = 0; k < 4; k++) begin
      ld_word[8*k +: 8] = ds_rdata[2'(s2_r.a0 + 2'(k))];
    end
  end

  assign s2_wval = s2_r.is_lw ? ld_word : s2_r.wval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------- output register
  logic        out_valid_r;
  logic [31:0] out_next_pc_r;
  logic        out_branch_taken_r;
  logic        out_write_valid_r;
  logic [4:0]  out_write_index_r;
  logic [31:0] out_write_value_r;
  logic        out_halted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_next_pc_r      <= s2_r.npc;
      out_branch_taken_r <= s2_r.taken;
      out_write_valid_r  <= s2_r.wv;
      out_write_index_r  <= s2_r.wi;
      out_write_value_r  <= s2_wval;
      out_halted_r       <= s2_r.halted;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_next_pc_r;
  assign out_branch_taken = out_branch_taken_r;
  assign out_write_valid  = out_write_valid_r;
  assign out_write_index  = out_write_index_r;
  assign out_write_value  = out_write_value_r;
  assign out_halted       = out_halted_r;

  // ---------------------------------------------------------------- assertions
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall)
    else $error("input transfer possible during data store clear");

  a_halted_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_halted_r) |-> (!out_write_valid_r && !out_branch_taken_r))
    else $error("halted result reports a write or a taken branch");

  a_no_write_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_write_valid_r) |->
      (out_write_index_r == 5'd0 && out_write_value_r == 32'd0))
    else $error("write fields nonzero without a write-back");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  a_rf_write_reported: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |=> (out_valid_r && out_write_valid_r && out_write_value_r == lw_val_r))
    else $error("register write-back not reported on the result");

endmodule

`default_nettype wire
